// File: hdl/urx_pkg.sv
// Shared types, codes and defaults for the UART receive FIFO register block.
`default_nettype none
package urx_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int SPEED_BITS_DEF = 16;

  localparam logic [1:0] MODE_LINE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [6:0] REG_STATUS = 7'd0;
  localparam logic [6:0] REG_SPEED  = 7'd1;
  localparam logic [6:0] REG_RXDATA = 7'd2;
  localparam logic [6:0] REG_TXDATA = 7'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  reg_address;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    logic [7:0]  requester;
  } in_item_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_target;
    logic        reply_is_data;
    logic [7:0]  reply_byte;
    logic        reply_empty_error;
    logic        status_empty;
    logic        status_overflow;
    logic        status_read_empty;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [15:0] speed_value;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_byte;
  } fifo_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: hdl/urx_ifs.sv
// Valid/ready channel interfaces for the item and result transactions.
`default_nettype none
interface urx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  reg_address;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;
  logic [7:0]  requester;

  modport source (output valid, mode, reg_address, write_value, rx_byte, requester,
                  input ready);
  modport sink (input valid, mode, reg_address, write_value, rx_byte, requester,
                output ready);
endinterface

interface urx_out_if;
  logic        valid;
  logic        ready;
  logic        reply_valid;
  logic [7:0]  reply_target;
  logic        reply_is_data;
  logic [7:0]  reply_byte;
  logic        reply_empty_error;
  logic        status_empty;
  logic        status_overflow;
  logic        status_read_empty;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [15:0] speed_value;

  modport source (output valid, reply_valid, reply_target, reply_is_data, reply_byte,
                  reply_empty_error, status_empty, status_overflow, status_read_empty,
                  tx_valid, tx_byte, speed_value,
                  input ready);
  modport sink (input valid, reply_valid, reply_target, reply_is_data, reply_byte,
                reply_empty_error, status_empty, status_overflow, status_read_empty,
                tx_valid, tx_byte, speed_value,
                output ready);
endinterface
`default_nettype wire

// File: hdl/urx_fifo.sv
// Receive FIFO: byte memory, pointers, full/empty flags and registered head byte.
`default_nettype none
module urx_fifo
  import urx_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire fifo_cmd_t  cmd,
  output fifo_stat_t      stat
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic          full;
  logic          empty;
  logic [7:0]    head;

  logic          push_ok;
  logic          pop_ok;
  logic [AW-1:0] rd_inc;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] rd_sel;

  assign push_ok = go && cmd.push && !full;
  assign pop_ok  = go && cmd.pop && !empty;
  assign rd_inc  = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_inc  = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_sel  = pop_ok ? rd_inc : rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      full   <= 1'b0;
      empty  <= 1'b1;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_inc;
        empty  <= 1'b0;
        full   <= (wr_inc == rd_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= rd_inc;
        full   <= 1'b0;
        empty  <= (rd_inc == wr_ptr);
      end
    end
  end

  // head always holds the entry at the read pointer; bypass a same-cycle write
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= cmd.push_byte;
    end
    if (push_ok && (wr_ptr == rd_sel)) begin
      head <= cmd.push_byte;
    end else begin
      head <= mem[rd_sel];
    end
  end

  assign stat.empty = empty;
  assign stat.full  = full;
  assign stat.head  = head;

endmodule
`default_nettype wire

// File: hdl/urx_ctrl.sv
// Register decode, status and speed registers, and result assembly.
`default_nettype none
module urx_ctrl
  import urx_pkg::*;
#(
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire in_item_t   item,
  input  wire fifo_stat_t fstat,
  output fifo_cmd_t       fcmd,
  output out_item_t       res
);

  logic                  overflow;
  logic                  read_empty;
  logic [SPEED_BITS-1:0] speed;
  logic                  overflow_next;
  logic                  read_empty_next;
  logic [SPEED_BITS-1:0] speed_next;
  logic [31:0]           speed_wide;

  logic is_line;
  logic is_write;
  logic is_read;
  logic rd_status;
  logic rd_data;

  assign is_line   = (item.mode == MODE_LINE);
  assign is_write  = (item.mode == MODE_WRITE);
  assign is_read   = (item.mode == MODE_READ);
  assign rd_status = is_read && (item.reg_address == REG_STATUS);
  assign rd_data   = is_read && (item.reg_address == REG_RXDATA);

  assign fcmd.push      = is_line;
  assign fcmd.pop       = rd_data;
  assign fcmd.push_byte = item.rx_byte;

  always_comb begin
    overflow_next   = overflow;
    read_empty_next = read_empty;
    speed_next      = speed;
    if (is_line && fstat.full) begin
      overflow_next = 1'b1;
    end
    if (is_write && (item.reg_address == REG_SPEED)) begin
      speed_next = SPEED_BITS'(item.write_value);
    end
    if (rd_status) begin
      overflow_next   = 1'b0;
      read_empty_next = 1'b0;
    end
    if (rd_data && fstat.empty) begin
      read_empty_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow   <= 1'b0;
      read_empty <= 1'b0;
      speed      <= SPEED_BITS'(1);
    end else if (go) begin
      overflow   <= overflow_next;
      read_empty <= read_empty_next;
      speed      <= speed_next;
    end
  end

  assign speed_wide = 32'(speed_next);

  always_comb begin
    res                   = '0;
    res.speed_value       = speed_wide[15:0];
    if (is_write && (item.reg_address == REG_TXDATA)) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = item.write_value[7:0];
    end
    if (rd_status) begin
      res.reply_valid       = 1'b1;
      res.reply_target      = item.requester;
      res.status_empty      = fstat.empty;
      res.status_overflow   = overflow;
      res.status_read_empty = read_empty;
    end
    if (rd_data) begin
      res.reply_valid       = 1'b1;
      res.reply_target      = item.requester;
      res.reply_is_data     = 1'b1;
      res.reply_empty_error = fstat.empty;
      res.reply_byte        = fstat.empty ? 8'd0 : fstat.head;
    end
  end

endmodule
`default_nettype wire

// File: hdl/uart_rx_fifo_bus_registers.sv
// UART register block with receive FIFO: top level with input and result registers.
//
// Usage:
//   item   : valid/ready sink. Each transaction is a line byte (mode 0), a bus
//            register write (mode 1) or a bus register read (mode 2).
//   result : valid/ready source. Exactly one result transaction per item, in
//            order, carrying any read reply, any tx byte and the speed register.
// Path: an accepted item waits in the input register until the result register is
//   free or being read; its work then moves into the result register.
// Throughput: 1 item per cycle while result.ready is high; decode, flag update and
//   FIFO push or pop all take place between the two registers, and the FIFO head
//   byte is kept prefetched from the memory read port.
// Reset: FIFO empty, overflow and read-empty cleared, speed register = 1;
//   both registers drop valid.
// Stall: when result.ready is low the result register holds, the input
//   register then holds, and item.ready falls; nothing is lost or repeated.
`default_nettype none
module uart_rx_fifo_bus_registers
  import urx_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  urx_in_if.sink    item,
  urx_out_if.source result
);

  in_item_t   in_q;
  logic       in_v;
  out_item_t  out_q;
  logic       out_v;
  logic       go;
  out_item_t  res;
  fifo_cmd_t  fcmd;
  fifo_stat_t fstat;

  assign go         = in_v && (!out_v || result.ready);
  assign item.ready = !in_v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (item.ready) begin
        in_v <= item.valid;
      end
      if (go) begin
        out_v <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q.mode        <= item.mode;
      in_q.reg_address <= item.reg_address;
      in_q.write_value <= item.write_value;
      in_q.rx_byte     <= item.rx_byte;
      in_q.requester   <= item.requester;
    end
    if (go) begin
      out_q <= res;
    end
  end

  urx_ctrl #(
    .SPEED_BITS (SPEED_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .item  (in_q),
    .fstat (fstat),
    .fcmd  (fcmd),
    .res   (res)
  );

  urx_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .cmd  (fcmd),
    .stat (fstat)
  );

  assign result.valid             = out_v;
  assign result.reply_valid       = out_q.reply_valid;
  assign result.reply_target      = out_q.reply_target;
  assign result.reply_is_data     = out_q.reply_is_data;
  assign result.reply_byte        = out_q.reply_byte;
  assign result.reply_empty_error = out_q.reply_empty_error;
  assign result.status_empty      = out_q.status_empty;
  assign result.status_overflow   = out_q.status_overflow;
  assign result.status_read_empty = out_q.status_read_empty;
  assign result.tx_valid          = out_q.tx_valid;
  assign result.tx_byte           = out_q.tx_byte;
  assign result.speed_value       = out_q.speed_value;

endmodule
`default_nettype wire

// File: sim/tb_uart_rx_fifo_bus_registers.sv
// Self-checking testbench for the UART receive FIFO register block.
`timescale 1ns / 100ps
module tb_uart_rx_fifo_bus_registers;
  import urx_pkg::*;

  localparam int DEPTH    = FIFO_DEPTH_DEF;
  localparam int WDOG_MAX = 2000;

  logic clk;
  logic rst;

  urx_in_if  item_if();
  urx_out_if result_if();

  uart_rx_fifo_bus_registers u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  // predicted block state
  logic [7:0]                fifo_mem [DEPTH];
  int                        rd_ptr;
  int                        wr_ptr;
  logic                      fifo_full;
  logic                      fifo_empty;
  logic                      rx_overflow;
  logic                      rx_read_empty;
  logic [SPEED_BITS_DEF-1:0] speed_exp;

  out_item_t response_q [$];
  int        err_count;
  int        src_idle_pct;
  int        snk_idle_pct;
  int        wdog_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void predict_uart_response(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.mode)
      MODE_LINE: begin
        if (fifo_full) begin
          rx_overflow = 1'b1;
        end else begin
          fifo_mem[wr_ptr] = it.rx_byte;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          fifo_empty = 1'b0;
          if (wr_ptr == rd_ptr) fifo_full = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (it.reg_address == REG_TXDATA) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = it.write_value[7:0];
        end else if (it.reg_address == REG_SPEED) begin
          speed_exp = it.write_value;
        end
      end
      MODE_READ: begin
        if (it.reg_address == REG_STATUS) begin
          r.reply_valid       = 1'b1;
          r.reply_target      = it.requester;
          r.status_empty      = fifo_empty;
          r.status_overflow   = rx_overflow;
          r.status_read_empty = rx_read_empty;
          rx_overflow   = 1'b0;
          rx_read_empty = 1'b0;
        end else if (it.reg_address == REG_RXDATA) begin
          r.reply_valid   = 1'b1;
          r.reply_target  = it.requester;
          r.reply_is_data = 1'b1;
          if (!fifo_empty) begin
            r.reply_byte = fifo_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fifo_full = 1'b0;
            if (rd_ptr == wr_ptr) fifo_empty = 1'b1;
          end else begin
            r.reply_empty_error = 1'b1;
            rx_read_empty = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.speed_value = 16'(speed_exp);
    response_q.push_back(r);
  endfunction

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [6:0] addr,
                                         input logic [15:0] wval, input logic [7:0] rxb,
                                         input logic [7:0] req);
    in_item_t it;
    it.mode        = mode;
    it.reg_address = addr;
    it.write_value = wval;
    it.rx_byte     = rxb;
    it.requester   = req;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] mode, input logic [6:0] addr);
    return make_item(mode, addr, 16'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.mode        <= it.mode;
    item_if.reg_address <= it.reg_address;
    item_if.write_value <= it.write_value;
    item_if.rx_byte     <= it.rx_byte;
    item_if.requester   <= it.requester;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    predict_uart_response(it);
  endtask

  task automatic test_empty_reads();
    send_item(make_item(MODE_READ, REG_RXDATA, 16'h0000, 8'h00, 8'h00));
    send_item(make_item(MODE_READ, REG_STATUS, 16'hffff, 8'hff, 8'hff));
  endtask

  task automatic test_bus_writes();
    send_item(make_item(MODE_WRITE, REG_SPEED, 16'hffff, 8'h00, 8'hff));
    send_item(make_item(MODE_WRITE, REG_TXDATA, 16'hffff, 8'hff, 8'h00));
    send_item(make_item(MODE_WRITE, 7'h7f, 16'h0000, 8'h00, 8'h00));
    send_item(make_item(2'd3, 7'h7f, 16'hffff, 8'hff, 8'hff));
    send_item(make_item(MODE_READ, 7'h7f, 16'h0000, 8'hff, 8'hff));
  endtask

  task automatic test_fill_overflow();
    logic [7:0] b;
    for (int i = 0; i <= DEPTH; i++) begin
      b = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom);
      send_item(make_item(MODE_LINE, 7'($urandom), 16'($urandom), b, 8'($urandom)));
    end
    send_item(make_item(MODE_READ, REG_STATUS, 16'h0000, 8'h00, 8'h5a));
  endtask

  // bursts of pushes and pops drive the FIFO through full and empty
  task automatic test_random_traffic(input int n_items);
    int         done;
    int         pick;
    int         burst;
    logic [6:0] addr;
    logic [15:0] wval;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        burst = $urandom_range(1, 20);
        repeat (burst) send_item(rand_item(MODE_LINE, 7'($urandom)));
        done += burst;
      end else if (pick < 55) begin
        burst = $urandom_range(1, 20);
        repeat (burst) send_item(rand_item(MODE_READ, REG_RXDATA));
        done += burst;
      end else if (pick < 65) begin
        send_item(rand_item(MODE_READ, REG_STATUS));
        done++;
      end else if (pick < 75) begin
        send_item(rand_item(MODE_WRITE, REG_TXDATA));
        done++;
      end else if (pick < 82) begin
        case ($urandom_range(3))
          0:       wval = 16'h0000;
          1:       wval = 16'hffff;
          default: wval = 16'($urandom);
        endcase
        send_item(make_item(MODE_WRITE, REG_SPEED, wval, 8'($urandom), 8'($urandom)));
        done++;
      end else if (pick < 88) begin
        addr = 7'($urandom);
        if (addr == REG_SPEED || addr == REG_TXDATA) addr = REG_STATUS;
        send_item(rand_item(MODE_WRITE, addr));
        done++;
      end else if (pick < 94) begin
        addr = 7'($urandom);
        if (addr == REG_STATUS || addr == REG_RXDATA) addr = REG_TXDATA;
        send_item(rand_item(MODE_READ, addr));
        done++;
      end else begin
        send_item(rand_item(2'd3, 7'($urandom)));
        done++;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      if (result_if.valid && result_if.ready) begin
        if (response_q.size() == 0) begin
          $error("result transaction with no expected response");
          err_count++;
        end else begin
          want = response_q.pop_front();
          check_field("reply_valid", 16'(want.reply_valid), 16'(result_if.reply_valid));
          check_field("reply_target", 16'(want.reply_target),
                      16'(result_if.reply_target));
          check_field("reply_is_data", 16'(want.reply_is_data),
                      16'(result_if.reply_is_data));
          check_field("reply_byte", 16'(want.reply_byte), 16'(result_if.reply_byte));
          check_field("reply_empty_error", 16'(want.reply_empty_error),
                      16'(result_if.reply_empty_error));
          check_field("status_empty", 16'(want.status_empty),
                      16'(result_if.status_empty));
          check_field("status_overflow", 16'(want.status_overflow),
                      16'(result_if.status_overflow));
          check_field("status_read_empty", 16'(want.status_read_empty),
                      16'(result_if.status_read_empty));
          check_field("tx_valid", 16'(want.tx_valid), 16'(result_if.tx_valid));
          check_field("tx_byte", 16'(want.tx_byte), 16'(result_if.tx_byte));
          check_field("speed_value", want.speed_value, result_if.speed_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      wdog_cycles <= 0;
    end else if (wdog_cycles >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      wdog_cycles <= wdog_cycles + 1;
    end
  end

  initial begin
    rst                 <= 1'b1;
    item_if.valid       <= 1'b0;
    item_if.mode        <= MODE_LINE;
    item_if.reg_address <= REG_STATUS;
    item_if.write_value <= '0;
    item_if.rx_byte     <= '0;
    item_if.requester   <= '0;
    err_count     = 0;
    src_idle_pct  = 19;
    snk_idle_pct  = 65;
    rd_ptr        = 0;
    wr_ptr        = 0;
    fifo_full     = 1'b0;
    fifo_empty    = 1'b1;
    rx_overflow   = 1'b0;
    rx_read_empty = 1'b0;
    speed_exp     = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_reads();
    test_bus_writes();
    test_fill_overflow();
    test_random_traffic(310);
    src_idle_pct = 65;
    snk_idle_pct = 19;
    test_random_traffic(310);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(310);

    item_if.valid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && response_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/urx_pkg.sv
hdl/urx_ifs.sv
hdl/urx_fifo.sv
hdl/urx_ctrl.sv
hdl/uart_rx_fifo_bus_registers.sv
sim/tb_uart_rx_fifo_bus_registers.sv
